FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/dlfr_pkg.sv
// Constants and beat types of the dimmer link frame receiver.
package dlfr_pkg;

	localparam int FRAME_BUFFER_BYTES = 256;
	localparam int HEAD_DEPTH = 17;
	localparam int HEAD_IDX_W = $clog2(HEAD_DEPTH);

	localparam logic [7:0] START_MARK   = 8'h01;
	localparam logic [7:0] END_MARK     = 8'h04;
	localparam logic [7:0] CMD_SWITCH   = 8'h01;
	localparam logic [7:0] CMD_POLL     = 8'h10;
	localparam logic [7:0] CMD_VERSION  = 8'h11;
	localparam logic [7:0] CMD_SETTINGS = 8'h20;
	localparam logic [7:0] ACK_OK       = 8'h01;
	localparam logic [7:0] POLL_MIN_LEN = 8'd17;
	localparam logic [7:0] VER_MIN_LEN  = 8'd2;
	localparam logic [7:0] HEADER_END   = 8'd4;

	localparam logic [1:0] STATUS_ABSORBED = 2'd0;
	localparam logic [1:0] STATUS_DROPPED  = 2'd1;
	localparam logic [1:0] STATUS_COMPLETE = 2'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic [7:0] expected_sequence;
	} rx_beat_t;

	typedef struct packed {
		logic [1:0]  frame_status;
		logic        reply_accepted;
		logic [7:0]  reply_command;
		logic [7:0]  hardware_revision;
		logic [15:0] reported_brightness;
		logic [31:0] power_period;
		logic [31:0] voltage_period;
		logic [31:0] current_period;
		logic [7:0]  reported_fade_rate;
		logic [7:0]  firmware_minor;
		logic [7:0]  firmware_major;
	} reply_beat_t;

endpackage

FILE: design/dlfr_rx_if.sv
// Valid/ready channel that carries received bytes.
interface dlfr_rx_if;
	import dlfr_pkg::*;
	logic     valid;
	logic     ready;
	rx_beat_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/dlfr_reply_if.sv
// Valid/ready channel that carries one result beat per received byte.
interface dlfr_reply_if;
	import dlfr_pkg::*;
	logic        valid;
	logic        ready;
	reply_beat_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/dimmer_link_frame_receiver.sv
// Deframer for the reply channel of a dimmer link: one result beat per received byte.
// Each received byte is first captured in an input register; when the output register
// can take a result, a single pass of logic updates the frame position, held header,
// running checksum and the first 17 payload bytes, and loads one result beat into the
// output register. A new byte is taken every cycle while the result side does not
// stall, so the sustained rate is then one byte per clock. Both registers hold when the
// result side stalls; the input register frees as soon as its byte moves on.
`include "assert_macros.svh"

module dimmer_link_frame_receiver (
	input  logic         clk,
	input  logic         arst_n,
	dlfr_rx_if.sink      rx,
	dlfr_reply_if.source reply
);
	import dlfr_pkg::*;

	logic        valid_s1;
	rx_beat_t    rx_s1;
	logic        out_valid_q;
	reply_beat_t out_q;
	logic        advance;

	logic [7:0]  pos_q, held_seq_q, held_cmd_q, held_len_q, prev_q;
	logic [15:0] sum_q;
	logic [7:0]  head_q [HEAD_DEPTH];

	logic [7:0]  pos_d, seq_d, cmd_d, len_d;
	logic [15:0] sum_d;
	logic        head_we;
	logic [7:0]  idx;
	logic        drop, complete;
	reply_beat_t res;

	logic [8:0]  pos_x, len_x;
	logic [9:0]  need_x;
	logic [7:0]  c;

	assign advance = !out_valid_q || reply.ready;
	assign rx.ready = !valid_s1 || advance;
	assign reply.valid = out_valid_q;
	assign reply.payload = out_q;

	assign c = rx_s1.rx_byte;
	assign pos_x = {1'b0, pos_q};
	assign len_x = {1'b0, held_len_q};
	assign need_x = {2'b00, held_len_q} + 10'd7;
	assign idx = pos_q - HEADER_END;

	always_comb begin
		pos_d = pos_q;
		seq_d = held_seq_q;
		cmd_d = held_cmd_q;
		len_d = held_len_q;
		sum_d = sum_q;
		head_we = 1'b0;
		drop = 1'b0;
		complete = 1'b0;
		if (pos_q == 8'd0) begin
			if (c == START_MARK) begin
				sum_d = '0;
				pos_d = 8'd1;
			end else begin
				drop = 1'b1;
			end
		end else if (pos_q < HEADER_END) begin
			if (pos_q == 8'd1) seq_d = c;
			else if (pos_q == 8'd2) cmd_d = c;
			else len_d = c;
			sum_d = sum_q + {8'd0, c};
			pos_d = pos_q + 8'd1;
		end else if (need_x > 10'(FRAME_BUFFER_BYTES)) begin
			drop = 1'b1;
		end else if (pos_x < len_x + 9'd4) begin
			head_we = (idx < 8'(HEAD_DEPTH));
			sum_d = sum_q + {8'd0, c};
			pos_d = pos_q + 8'd1;
		end else if (pos_x == len_x + 9'd4) begin
			pos_d = pos_q + 8'd1;
		end else if (pos_x == len_x + 9'd5) begin
			if ({prev_q, c} != sum_q) drop = 1'b1;
			else pos_d = pos_q + 8'd1;
		end else if (pos_x == len_x + 9'd6) begin
			if (c == END_MARK) begin
				complete = 1'b1;
				pos_d = 8'd0;
			end else begin
				drop = 1'b1;
			end
		end else begin
			drop = 1'b1;
		end
		if (drop) pos_d = 8'd0;
	end

	always_comb begin
		res = '0;
		if (drop) begin
			res.frame_status = STATUS_DROPPED;
		end else if (complete) begin
			res.frame_status = STATUS_COMPLETE;
			res.reply_command = held_cmd_q;
			if (held_seq_q == rx_s1.expected_sequence) begin
				case (held_cmd_q)
					CMD_POLL: begin
						if (held_len_q >= POLL_MIN_LEN) begin
							res.reply_accepted = 1'b1;
							res.hardware_revision = head_q[0];
							res.reported_brightness = {head_q[3], head_q[2]};
							res.power_period = {head_q[7], head_q[6], head_q[5], head_q[4]};
							res.voltage_period = {head_q[11], head_q[10], head_q[9], head_q[8]};
							res.current_period = {head_q[15], head_q[14], head_q[13], head_q[12]};
							res.reported_fade_rate = head_q[16];
						end
					end
					CMD_VERSION: begin
						if (held_len_q >= VER_MIN_LEN) begin
							res.reply_accepted = 1'b1;
							res.firmware_minor = head_q[0];
							res.firmware_major = head_q[1];
						end
					end
					CMD_SWITCH, CMD_SETTINGS: begin
						res.reply_accepted = (held_len_q != 8'd0) && (head_q[0] == ACK_OK);
					end
					default: begin
						res.reply_accepted = 1'b0;
					end
				endcase
			end
		end else begin
			res.frame_status = STATUS_ABSORBED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q <= '0;
			held_seq_q <= '0;
			held_cmd_q <= '0;
			held_len_q <= '0;
			sum_q <= '0;
			prev_q <= '0;
		end else begin
			if (rx.ready) valid_s1 <= rx.valid;
			if (advance) out_valid_q <= valid_s1;
			if (advance && valid_s1) begin
				pos_q <= pos_d;
				held_seq_q <= seq_d;
				held_cmd_q <= cmd_d;
				held_len_q <= len_d;
				sum_q <= sum_d;
				prev_q <= c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) rx_s1 <= rx.payload;
		if (advance && valid_s1) out_q <= res;
		if (advance && valid_s1 && head_we) head_q[idx[HEAD_IDX_W-1:0]] <= c;
	end

	`ASSERT_IMPLIES(a_accept_complete, clk, arst_n, reply.valid && reply.payload.reply_accepted, reply.payload.frame_status == STATUS_COMPLETE)
	`ASSERT_IMPLIES(a_pos_bound, clk, arst_n, pos_q >= HEADER_END, pos_x <= len_x + 9'd6)
	`ASSERT_NEXT(a_start_mark, clk, arst_n, advance && valid_s1 && pos_q == 8'd0 && c == START_MARK, pos_q == 8'd1)

endmodule
